// File: src/ipv4_text_validator_unit_defines.svh
// assertion macros for the ipv4 text validator
// expects signals clk and rst in the scope of each use
`ifndef IPV4_TEXT_VALIDATOR_UNIT_DEFINES_SVH
`define IPV4_TEXT_VALIDATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled in reset
`define IPV4V_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled in reset
`define IPV4V_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IPV4V_ASSERT_NOW(label, ante, cons, msg)
`define IPV4V_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: src/ipv4v_pkg.sv
// shared types and constants for the ipv4 text validator
// no dependencies
package ipv4v_pkg;

  localparam int unsigned MAX_LENGTH = 15;

  localparam logic [7:0] CH_TERM = 8'h00;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  localparam logic [4:0] CHAR_COUNT_MAX   = 5'd31;
  localparam logic [2:0] COUNT3_MAX       = 3'd7;
  localparam logic [2:0] OCTET_MAX_DIGITS = 3'd3;
  localparam logic [2:0] DOTS_EXPECTED    = 3'd3;
  localparam logic [9:0] OCTET_MAX_VALUE  = 10'd255;
  localparam logic [9:0] OCTET_VALUE_LIM  = 10'd1000;

  typedef enum logic [2:0] {
    ST_VALID     = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_BAD_CHAR  = 3'd2,
    ST_DOT_COUNT = 3'd3,
    ST_BAD_OCTET = 3'd4
  } status_t;

endpackage

// File: src/ipv4v_if.sv
// handshake channels for the ipv4 text validator: characters in, status out
// depends on nothing
interface ipv4v_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface ipv4v_status_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface

// File: src/ipv4_text_validator_unit.sv
// ipv4 dotted-decimal text validator, top level
// depends on ipv4v_pkg, ipv4v_if.sv and ipv4_text_validator_unit_defines.svh
//
// Takes a text string one character word per cycle on chars and judges it as
// an IPv4 dotted-decimal address. A zero byte ends the string: that word gives
// one status word on result and clears all state, any other byte gives no
// result. Status in priority order: 1 more than MAX_LENGTH characters, 2 a
// byte other than a digit or a dot, 3 not exactly three dots, 4 an octet with
// more than three digits, above 255, or a leading zero with more digits after
// it, otherwise 0. Empty octets pass. Each character passes through an input
// register and updates the counters as it leaves it; the status sits in an
// output register. One character is taken every cycle; a terminator stalls
// only while the previous status has not yet been taken downstream.
`include "ipv4_text_validator_unit_defines.svh"

module ipv4_text_validator_unit (
  input  logic                  clk,
  input  logic                  rst,
  ipv4v_char_if.sink            chars,
  ipv4v_status_if.source        result
);

  // input register
  logic       in_valid;
  logic [7:0] in_ch;

  // string state
  logic [4:0] char_count;
  logic [2:0] dot_count;
  logic [2:0] octet_digits;
  logic [9:0] octet_value;
  logic       leading_zero;
  logic       octet_bad;
  logic       char_bad;

  // output register
  logic                 out_valid;
  ipv4v_pkg::status_t   out_status;

  logic       is_term;
  logic       is_digit;
  logic       is_dot;
  logic       advance;
  logic       octet_fails;
  logic [3:0] digit;
  ipv4v_pkg::status_t status_next;

  assign is_term  = (in_ch == ipv4v_pkg::CH_TERM);
  assign is_digit = (in_ch >= ipv4v_pkg::CH_ZERO) && (in_ch <= ipv4v_pkg::CH_NINE);
  assign is_dot   = (in_ch == ipv4v_pkg::CH_DOT);
  assign digit    = in_ch[3:0];

  // a terminator needs the output register free, any other character moves on
  assign advance = in_valid && (!is_term || !out_valid || result.ready);
  assign chars.ready = !in_valid || advance;

  assign octet_fails = (octet_digits > ipv4v_pkg::OCTET_MAX_DIGITS)
                    || (octet_value > ipv4v_pkg::OCTET_MAX_VALUE)
                    || (leading_zero && (octet_digits != 3'd1));

  // verdict for the terminator, highest priority first
  always_comb begin
    priority if (5'(ipv4v_pkg::MAX_LENGTH) < char_count) begin
      status_next = ipv4v_pkg::ST_TOO_LONG;
    end else if (char_bad) begin
      status_next = ipv4v_pkg::ST_BAD_CHAR;
    end else if (dot_count != ipv4v_pkg::DOTS_EXPECTED) begin
      status_next = ipv4v_pkg::ST_DOT_COUNT;
    end else if (octet_bad || octet_fails) begin
      status_next = ipv4v_pkg::ST_BAD_OCTET;
    end else begin
      status_next = ipv4v_pkg::ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      in_ch <= chars.ch;
    end
  end

  // counter updates as a character leaves the input register
  always_ff @(posedge clk) begin
    if (rst || (advance && is_term)) begin
      char_count   <= '0;
      dot_count    <= '0;
      octet_digits <= '0;
      octet_value  <= '0;
      leading_zero <= 1'b0;
      octet_bad    <= 1'b0;
      char_bad     <= 1'b0;
    end else if (advance) begin
      if (char_count != ipv4v_pkg::CHAR_COUNT_MAX) begin
        char_count <= char_count + 5'd1;
      end
      if (is_digit) begin
        if ((octet_digits == 3'd0) && (digit == 4'd0)) begin
          leading_zero <= 1'b1;
        end
        // digits past the third leave the value alone
        if (octet_digits < ipv4v_pkg::OCTET_MAX_DIGITS) begin
          octet_value <= 10'(octet_value * 10'd10 + 10'(digit));
        end
        if (octet_digits != ipv4v_pkg::COUNT3_MAX) begin
          octet_digits <= octet_digits + 3'd1;
        end
      end else if (is_dot) begin
        if (dot_count != ipv4v_pkg::COUNT3_MAX) begin
          dot_count <= dot_count + 3'd1;
        end
        if (octet_fails) begin
          octet_bad <= 1'b1;
        end
        octet_digits <= '0;
        octet_value  <= '0;
        leading_zero <= 1'b0;
      end else begin
        char_bad <= 1'b1;
      end
    end
  end

  // status output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_term) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && is_term) begin
      out_status <= status_next;
    end
  end

  assign result.valid  = out_valid;
  assign result.status = out_status;

  // a new status only ever follows a terminator leaving the input register
  `IPV4V_ASSERT_NEXT(a_status_from_term, !(advance && is_term), !$rose(out_valid) || $past(rst), "status raised without a terminator")
  // the character and dot counts and the error flags are clear after a terminator
  `IPV4V_ASSERT_NEXT(a_clear_after_term, advance && is_term, (char_count == 5'd0) && (dot_count == 3'd0) && !char_bad && !octet_bad, "state not cleared after terminator")
  // the octet value keeps to three decimal digits
  `IPV4V_ASSERT_NOW(a_octet_range, 1'b1, octet_value < ipv4v_pkg::OCTET_VALUE_LIM, "octet value out of range")
  // a terminator never overwrites a status still waiting downstream
  `IPV4V_ASSERT_NOW(a_no_overwrite, advance && is_term && out_valid, result.ready, "pending status overwritten")

endmodule
